// File: rtl/cbsc_pkg.sv
package cbsc_pkg;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_WINDOW = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CLS_OFF   = 3'd0,
        CLS_8K    = 3'd1,
        CLS_16K   = 3'd2,
        CLS_FLEXI = 3'd3,
        CLS_FIXED = 3'd4,
        CLS_OSS   = 3'd5,
        CLS_SIC   = 3'd6,
        CLS_NONE  = 3'd7
    } t_class;

    localparam logic [7:0] OFF_PBANK_LO = 8'hA0;
    localparam logic [7:0] OFF_PBANK_HI = 8'hA1;
    localparam logic [7:0] OFF_PEN      = 8'hA2;
    localparam logic [7:0] OFF_SBANK_LO = 8'hA3;
    localparam logic [7:0] OFF_SBANK_HI = 8'hA4;
    localparam logic [7:0] OFF_SEN      = 8'hA5;
    localparam logic [7:0] OFF_MODE     = 8'hA6;
    localparam logic [7:0] OFF_SRC      = 8'hA7;
    localparam logic [7:0] OFF_SPI      = 8'hA8;
    localparam logic [7:0] OFF_LOCK     = 8'hAF;

    // bank-switch state carried between the item logic and the state registers
    typedef struct packed {
        logic [15:0] pbank;
        logic        pen;
        logic [13:0] sbank;
        logic        sen;
        logic [5:0]  mode;
        logic [3:0]  src;
        logic [7:0]  spi;
        logic        locked;
        t_class      cls;
        logic [1:0]  split;
        logic [1:0]  small_sel;
    } t_state;

    function automatic t_class class_of(input logic [5:0] m, input t_class prev);
        t_class c;
        c = prev;
        if (m == 6'h00) c = CLS_OFF;
        else if (m == 6'h01 || m == 6'h02 || m == 6'h03 || m == 6'h08 || m == 6'h09 ||
                 m == 6'h0A || m == 6'h0C || m == 6'h0D) c = CLS_8K;
        else if (m == 6'h21 || m == 6'h22 || m == 6'h23 || (m >= 6'h28)) begin
            if (m < 6'h30) c = CLS_16K;
            else if (m <= 6'h35 || (m >= 6'h38 && m <= 6'h3D)) c = CLS_FIXED;
        end
        else if (m == 6'h20) c = CLS_FLEXI;
        else if (m == 6'h04) c = CLS_OSS;
        else if (m == 6'h24) c = CLS_SIC;
        return c;
    endfunction

    function automatic logic by_address(input logic [5:0] m);
        return m == 6'h02 || m == 6'h03 || m == 6'h04 || m == 6'h08 || m == 6'h09 ||
               m == 6'h0A || m == 6'h0D || m == 6'h22;
    endfunction

    function automatic logic [7:0] bank_mask(input logic [5:0] m);
        logic [7:0] r;
        r = 8'h00;
        unique case (m)
            6'h02, 6'h0C: r = 8'h0F;
            6'h03: r = 8'h7F;
            6'h04: r = 8'h01;
            6'h08, 6'h09, 6'h0A, 6'h0D: r = 8'h07;
            6'h22: r = 8'hFE;
            6'h24: r = 8'h3E;
            default: begin
                if (m >= 6'h28 && m <= 6'h2F) r = 8'((9'd2 << m[2:0]) - 9'd2);
                else if (m >= 6'h30 && m <= 6'h35) r = 8'((9'd4 << m[2:0]) - 9'd1);
                else if (m >= 6'h38 && m <= 6'h3D) r = 8'((9'd4 << m[2:0]) - 9'd1);
            end
        endcase
        return r;
    endfunction

    // bit 16 flags a key that does nothing
    function automatic logic [16:0] bank_info(input logic [5:0] m, input logic [7:0] k);
        logic [16:0] r;
        logic [7:0]  base;
        logic [7:0]  d;
        r = 17'h10000;
        base = (m == 6'h08) ? 8'hE0 : (m == 6'h09) ? 8'hD0 : 8'h70;
        d = k - base;
        unique case (m)
            6'h02: begin
                if (k < 8'h10) r = {1'b0, 16'h4000 | 16'(k)};
                else if (k < 8'h20) r = {1'b0, 8'h00, k};
            end
            6'h03: begin
                if (k < 8'h80) r = {1'b0, 16'h4000 | 16'(k)};
                else if (k < 8'h90) r = {1'b0, 8'h00, k};
            end
            6'h04: begin
                unique case ({k[3], k[0]})
                    2'b00: r = 17'd1;
                    2'b01: r = 17'd3;
                    2'b10: r = 17'h1FFFF;
                    default: r = 17'd2;
                endcase
            end
            6'h08, 6'h09, 6'h0A: begin
                if (k >= base && d < 8'd8) r = {1'b0, 16'h4007 - 16'(d)};
                else if (k >= base && d < 8'd16) r = {1'b0, 16'd15 - 16'(d)};
            end
            6'h0C: r = k[7] ? {1'b0, 9'd0, k[6:0]} : {1'b0, 16'h4000 | 16'(k)};
            6'h0D: r = k[3] ? {1'b0, 8'h00, k} : {1'b0, 16'h4000 | 16'(k)};
            6'h23: r = 17'd0;
            6'h24: r = {1'b0, 1'b0, ~k[6], k[5], 7'd0, k[4:0], 1'b0};
            default: begin
                if (m == 6'h22 || (m >= 6'h28 && m <= 6'h2F))
                    r = k[7] ? {1'b0, 8'h00, k[6:0], 1'b0} : {1'b0, 8'h40, k[6:0], 1'b0};
                else if (m >= 6'h30 && m <= 6'h35) r = {1'b0, 16'h4000 | 16'(k)};
                else if (m >= 6'h38 && m <= 6'h3D) r = {1'b0, 1'b0, k[7], 6'd0, k};
            end
        endcase
        // OSS key with bits 3 and 0 as 1,0 gives -1
        if (m == 6'h04 && k[3] && !k[0]) r = 17'h10000;
        return r;
    endfunction

endpackage

// File: rtl/cbsc_map.sv
module cbsc_map (
    input  cbsc_pkg::t_state      st,
    input  logic [4:0]            size_log2,
    input  logic [15:0]           addr,
    input  logic                  is_window,
    output logic                  uon,
    output logic                  u4k,
    output logic [26:0]           uoff,
    output logic                  uram,
    output logic                  lon,
    output logic                  l4k,
    output logic [26:0]           loff,
    output logic                  lram,
    output logic [27:0]           full,
    output logic                  wr
);
    logic [13:0] pb, sb, ub, lb, pbe;
    logic [26:0] msk;
    logic [4:0]  lg;
    logic        pram, sram, pen, uwe, lwe;

    always_comb begin
        lg   = (size_log2 > 5'd27) ? 5'd27 : size_log2;
        msk  = 27'((28'd1 << lg) - 28'd1);
        pb   = st.pbank[13:0];
        sb   = st.sbank;
        pbe  = {pb[13:1], 1'b0};
        pram = st.src[1];
        sram = st.src[3];
        pen  = st.pen;
        uon = 1'b0; u4k = 1'b0; uram = 1'b0; lon = 1'b0; l4k = 1'b0; lram = 1'b0;
        ub = '0; lb = '0;
        unique case (st.cls)
            cbsc_pkg::CLS_8K: if (pen) begin
                uon = 1'b1; ub = pb; uram = pram;
            end
            cbsc_pkg::CLS_16K: if (pen) begin
                uon = 1'b1; lon = 1'b1; ub = pbe + 14'd1; lb = pbe; uram = pram; lram = pram;
            end
            cbsc_pkg::CLS_FLEXI: begin
                if (pen) begin
                    uon = 1'b1; ub = pb; uram = pram;
                end
                if (st.sen) begin
                    lon = 1'b1; lb = sb; lram = sram;
                end
            end
            cbsc_pkg::CLS_FIXED: if (pen) begin
                uon = 1'b1; lon = 1'b1; ub = pb | 14'(cbsc_pkg::bank_mask(st.mode));
                lb = pb; uram = pram; lram = pram;
            end
            cbsc_pkg::CLS_OSS: if (pen) begin
                uon = 1'b1; lon = 1'b1; u4k = 1'b1; l4k = 1'b1; ub = pb;
                uram = pram; lram = pram;
            end
            cbsc_pkg::CLS_SIC: if (pen) begin
                if (st.split[1]) begin
                    uon = 1'b1; ub = pbe + 14'd1; uram = pram;
                end
                if (st.split[0]) begin
                    lon = 1'b1; lb = pbe; lram = pram;
                end
            end
            default: ;
        endcase
        uoff = uon ? ({ub, 13'd0} & msk) : '0;
        if (!lon) loff = '0;
        else if (st.cls == cbsc_pkg::CLS_OSS)
            loff = ({pbe, 13'd0} + {13'd0, st.small_sel, 12'd0}) & msk;
        else
            loff = {lb, 13'd0} & msk;
        uwe = uon & st.src[0];
        if (st.cls == cbsc_pkg::CLS_OFF || st.cls == cbsc_pkg::CLS_8K ||
            st.cls == cbsc_pkg::CLS_FLEXI)
            lwe = lon & st.src[2];
        else
            lwe = lon & st.src[0];

        full = '0;
        wr   = 1'b0;
        if (is_window && addr >= 16'h8000 && addr < 16'hC000) begin
            priority if (uon && u4k && addr >= 16'hB000) begin
                full = {1'b0, uoff} + {16'd0, addr[11:0]}; wr = uwe;
            end else if (lon && l4k && addr >= 16'hA000 && addr < 16'hB000) begin
                full = {1'b0, loff} + {16'd0, addr[11:0]}; wr = lwe;
            end else if (uon && !u4k && addr >= 16'hA000) begin
                full = {1'b0, uoff} + {15'd0, addr[12:0]}; wr = uwe;
            end else if (lon && !l4k && addr < 16'hA000) begin
                full = {1'b0, loff} + {15'd0, addr[12:0]}; wr = lwe;
            end
        end
    end
endmodule

// File: rtl/cartridge_bank_switch_controller_top.sv
// Cartridge bank-switch controller. Each item is one bus event (control read,
// control write or cartridge window access) and yields one result item holding
// the read byte, the mapping of both windows after the event and, for window
// accesses, the translated image address and flash write permission. An item
// is registered on entry, handled by one level of decode and offset logic, and
// its result lands in an output register; one item per cycle is sustained while
// the receiver does not stall. The output register is refilled while its item is
// being taken, so the input only stalls when a result is held back.
// image_size_log2 is written through i_cfg_we and i_cfg_data; the user must do
// so only while the block is idle, as the block itself does not enforce it.
module cartridge_bank_switch_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_control_offset,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_window_address,
    input  logic        i_spi_data_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_upper_window_on,
    output logic        o_upper_window_4k,
    output logic [26:0] o_upper_offset,
    output logic        o_upper_in_ram,
    output logic        o_lower_window_on,
    output logic        o_lower_window_4k,
    output logic [26:0] o_lower_offset,
    output logic        o_lower_in_ram,
    output logic [27:0] o_full_address,
    output logic        o_access_writable,
    output logic [2:0]  o_spi_pins
);
    cbsc_pkg::t_state r_st, n_st;
    logic [4:0]  r_size;
    // input register
    logic        r_iv;
    logic [1:0]  r_cmd;
    logic [7:0]  r_off, r_dat;
    logic [15:0] r_addr;
    logic        r_din;
    logic [7:0]  n_rd;
    logic        adv, take;
    logic [7:0]  key, bm;
    logic [16:0] info;
    logic [15:0] inf, newb;
    logic        in_win;

    logic        m_uon, m_u4k, m_uram, m_lon, m_l4k, m_lram, m_wr;
    logic [26:0] m_uoff, m_loff;
    logic [27:0] m_full;

    // stage 1 advances when the output register is free or being emptied
    assign adv     = !o_valid || !i_stall;
    assign o_stall = r_iv && !adv;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (take || adv) begin
            r_iv <= take;
        end
        if (take) begin
            r_cmd  <= i_command;
            r_off  <= i_control_offset;
            r_dat  <= i_write_data;
            r_addr <= i_window_address;
            r_din  <= i_spi_data_in;
        end
    end

    // state update and read data for the item in the input register
    always_comb begin
        n_st   = r_st;
        n_rd   = 8'hFF;
        in_win = (r_off[7:4] == 4'hA) && !r_st.locked;
        key    = cbsc_pkg::by_address(r_st.mode) ? r_off :
                 ((r_cmd == cbsc_pkg::CMD_READ) ? 8'h00 : r_dat);
        info   = cbsc_pkg::bank_info(r_st.mode, key);
        inf    = info[15:0];
        bm     = cbsc_pkg::bank_mask(r_st.mode);
        newb   = r_st.pbank ^ ((r_st.pbank ^ inf) & ({8'h00, bm} | 16'h4000));
        if (r_cmd == cbsc_pkg::CMD_READ && in_win) begin
            unique case (r_off)
                cbsc_pkg::OFF_PBANK_LO: n_rd = r_st.pbank[7:0];
                cbsc_pkg::OFF_PBANK_HI: n_rd = r_st.pbank[15:8];
                cbsc_pkg::OFF_PEN:      n_rd = {7'd0, r_st.pen};
                cbsc_pkg::OFF_SBANK_LO: n_rd = r_st.sbank[7:0];
                cbsc_pkg::OFF_SBANK_HI: n_rd = {2'd0, r_st.sbank[13:8]};
                cbsc_pkg::OFF_SEN:      n_rd = {7'd0, r_st.sen};
                cbsc_pkg::OFF_MODE:     n_rd = {2'd0, r_st.mode};
                cbsc_pkg::OFF_SRC:      n_rd = {4'd0, r_st.src};
                cbsc_pkg::OFF_SPI:      n_rd = {r_din, 5'd0, r_st.spi[1:0]};
                default:                n_rd = 8'hFF;
            endcase
        end else if (r_cmd == cbsc_pkg::CMD_WRITE && in_win) begin
            unique case (r_off)
                cbsc_pkg::OFF_PBANK_LO: begin
                    n_st.pen = 1'b1; n_st.pbank[7:0] = r_dat;
                end
                cbsc_pkg::OFF_PBANK_HI: begin
                    n_st.pen = 1'b1; n_st.pbank[15:8] = {2'd0, r_dat[5:0]};
                end
                cbsc_pkg::OFF_PEN: n_st.pen = r_dat[0];
                cbsc_pkg::OFF_SBANK_LO: begin
                    n_st.sen = 1'b1; n_st.sbank[7:0] = r_dat;
                end
                cbsc_pkg::OFF_SBANK_HI: begin
                    n_st.sen = 1'b1; n_st.sbank[13:8] = r_dat[5:0];
                end
                cbsc_pkg::OFF_SEN: n_st.sen = r_dat[0];
                cbsc_pkg::OFF_MODE: begin
                    n_st.mode = r_dat[5:0];
                    n_st.cls  = cbsc_pkg::class_of(r_dat[5:0], r_st.cls);
                end
                cbsc_pkg::OFF_SRC:  n_st.src = r_dat[3:0];
                cbsc_pkg::OFF_SPI:  n_st.spi = r_dat & 8'h83;
                cbsc_pkg::OFF_LOCK: n_st.locked = 1'b1;
                default: ;
            endcase
        end else if (r_cmd == cbsc_pkg::CMD_READ && r_st.cls == cbsc_pkg::CLS_SIC &&
                     r_off < 8'h20) begin
            // SIC status byte
            n_rd = {1'b0, !r_st.pen, r_st.sen, r_st.pbank[5:1]};
        end else if ((r_cmd == cbsc_pkg::CMD_WRITE ||
                      (r_cmd == cbsc_pkg::CMD_READ && cbsc_pkg::by_address(r_st.mode)))
                     && !info[16]) begin
            if (r_st.cls == cbsc_pkg::CLS_SIC) begin
                if (r_off < 8'h20) begin
                    n_st.pbank = newb;
                    n_st.split = inf[14:13];
                end
            end else if (r_st.cls == cbsc_pkg::CLS_OSS) begin
                n_st.small_sel = inf[1:0];
            end else begin
                n_st.pbank = newb;
                n_st.pen   = inf[14];
            end
        end
    end

    cbsc_map u_map (
        .st        (n_st),
        .size_log2 (r_size),
        .addr      (r_addr),
        .is_window (r_cmd == cbsc_pkg::CMD_WINDOW),
        .uon       (m_uon),
        .u4k       (m_u4k),
        .uoff      (m_uoff),
        .uram      (m_uram),
        .lon       (m_lon),
        .l4k       (m_l4k),
        .loff      (m_loff),
        .lram      (m_lram),
        .full      (m_full),
        .wr        (m_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size         <= 5'd24;
            r_st.pbank     <= '0;
            r_st.pen       <= 1'b1;
            r_st.sbank     <= '0;
            r_st.sen       <= 1'b0;
            r_st.mode      <= 6'h01;
            r_st.src       <= '0;
            r_st.spi       <= 8'h82;
            r_st.locked    <= 1'b0;
            r_st.cls       <= cbsc_pkg::CLS_8K;
            r_st.split     <= 2'b10;
            r_st.small_sel <= '0;
            o_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) r_size <= i_cfg_data;
            if (r_iv && adv) r_st <= n_st;
            if (adv) o_valid <= r_iv;
        end
        if (r_iv && adv) begin
            o_read_data       <= n_rd;
            o_upper_window_on <= m_uon;
            o_upper_window_4k <= m_u4k;
            o_upper_offset    <= m_uoff;
            o_upper_in_ram    <= m_uram;
            o_lower_window_on <= m_lon;
            o_lower_window_4k <= m_l4k;
            o_lower_offset    <= m_loff;
            o_lower_in_ram    <= m_lram;
            o_full_address    <= m_full;
            o_access_writable <= m_wr;
            o_spi_pins        <= {n_st.spi[7], !n_st.spi[1], n_st.spi[0]};
        end
    end
endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cbsc_pkg::*;

    // one bus event and, for directed rows, an optional typed read byte
    typedef struct {
        t_cmd        cmd;
        logic [7:0]  off;
        logic [7:0]  dat;
        logic [15:0] addr;
        logic        din;
        bit          has_rd;
        logic [7:0]  rd;
    } bus_item_t;

    // mapping and translation reported for one item
    typedef struct {
        logic [7:0]  rd;
        logic        uon;
        logic        u4k;
        logic [26:0] uoff;
        logic        uram;
        logic        lon;
        logic        l4k;
        logic [26:0] loff;
        logic        lram;
        logic [27:0] full;
        logic        wr;
        logic [2:0]  spi;
    } map_result_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = '0;
    logic [7:0]  i_control_offset = '0;
    logic [7:0]  i_write_data = '0;
    logic [15:0] i_window_address = '0;
    logic        i_spi_data_in = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_upper_window_on;
    logic        o_upper_window_4k;
    logic [26:0] o_upper_offset;
    logic        o_upper_in_ram;
    logic        o_lower_window_on;
    logic        o_lower_window_4k;
    logic [26:0] o_lower_offset;
    logic        o_lower_in_ram;
    logic [27:0] o_full_address;
    logic        o_access_writable;
    logic [2:0]  o_spi_pins;

    cartridge_bank_switch_controller_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_control_offset  (i_control_offset),
        .i_write_data      (i_write_data),
        .i_window_address  (i_window_address),
        .i_spi_data_in     (i_spi_data_in),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_read_data       (o_read_data),
        .o_upper_window_on (o_upper_window_on),
        .o_upper_window_4k (o_upper_window_4k),
        .o_upper_offset    (o_upper_offset),
        .o_upper_in_ram    (o_upper_in_ram),
        .o_lower_window_on (o_lower_window_on),
        .o_lower_window_4k (o_lower_window_4k),
        .o_lower_offset    (o_lower_offset),
        .o_lower_in_ram    (o_lower_in_ram),
        .o_full_address    (o_full_address),
        .o_access_writable (o_access_writable),
        .o_spi_pins        (o_spi_pins)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the controller state, kept in step with accepted items
    logic [15:0] pbank;
    logic        pen;
    logic [13:0] sbank;
    logic        sen;
    logic [5:0]  mode;
    logic [3:0]  src;
    logic [7:0]  spi;
    logic        locked;
    t_class      cls;
    logic [1:0]  split;
    logic [1:0]  small_sel;
    logic [4:0]  size_log2;

    map_result_t mapping_q[$];   // expected mappings, oldest first
    int          errors = 0;
    bit          no_idle = 0;    // stretches with no gaps on either side
    bit          hold_req = 0;   // asks the receiver for one long hold-off

    // window class that a mode code selects; unknown codes keep the old class
    function automatic t_class mode_class(input logic [5:0] m, input t_class prev);
        if (m == 6'h00) return CLS_OFF;
        if (m inside {6'h01, 6'h02, 6'h03, 6'h08, 6'h09, 6'h0A, 6'h0C, 6'h0D}) return CLS_8K;
        if (m inside {6'h21, 6'h22, 6'h23, [6'h28:6'h2F]}) return CLS_16K;
        if (m == 6'h20) return CLS_FLEXI;
        if (m inside {[6'h30:6'h35], [6'h38:6'h3D]}) return CLS_FIXED;
        if (m == 6'h04) return CLS_OSS;
        if (m == 6'h24) return CLS_SIC;
        return prev;
    endfunction

    function automatic bit keyed_by_addr(input logic [5:0] m);
        return m inside {6'h02, 6'h03, 6'h04, 6'h08, 6'h09, 6'h0A, 6'h0D, 6'h22};
    endfunction

    function automatic int unsigned mode_mask(input logic [5:0] m);
        case (m)
            6'h02, 6'h0C: return 'h0F;
            6'h03: return 'h7F;
            6'h04: return 'h01;
            6'h08, 6'h09, 6'h0A, 6'h0D: return 'h07;
            6'h22: return 'hFE;
            6'h24: return 'h3E;
            default: ;
        endcase
        if (m inside {[6'h28:6'h2F]}) return (2 << (m - 6'h28)) - 2;
        if (m inside {[6'h30:6'h35]}) return (4 << (m - 6'h30)) - 1;
        if (m inside {[6'h38:6'h3D]}) return (4 << (m - 6'h38)) - 1;
        return 0;
    endfunction

    // new bank word bits for key k, or -1 when the key does nothing
    function automatic int switch_info(input logic [5:0] m, input int k);
        int base;
        case (m)
            6'h02: return (k < 'h10) ? 'h4000 + k : (k < 'h20) ? k : -1;
            6'h03: return (k < 'h80) ? 'h4000 + k : (k < 'h90) ? k : -1;
            6'h04: begin
                case (k & 9)
                    0: return 1;
                    1: return 3;
                    8: return -1;
                    default: return 2;
                endcase
            end
            6'h08, 6'h09, 6'h0A: begin
                base = (m == 6'h08) ? 'hE0 : (m == 6'h09) ? 'hD0 : 'h70;
                if (k >= base && k < base + 8) return 'h4007 - (k - base);
                if (k >= base + 8 && k < base + 16) return 7 - (k - base - 8);
                return -1;
            end
            6'h0C: return (k < 'h80) ? 'h4000 + k : k - 'h80;
            6'h0D: return (k & 8) ? k : 'h4000 + k;
            6'h23: return 0;
            6'h24: return ((k & 'h40) ? 0 : 'h4000) + ((k & 'h20) ? 'h2000 : 0) + (k & 'h1F) * 2;
            default: ;
        endcase
        if (m == 6'h22 || m inside {[6'h28:6'h2F]})
            return (k < 128) ? 'h4000 + k * 2 : (k - 128) * 2;
        if (m inside {[6'h30:6'h35]}) return 'h4000 + k;
        if (m inside {[6'h38:6'h3D]}) return ((k & 'h80) ? 'h4000 : 0) + k;
        return -1;
    endfunction

    function automatic void switch_banks(input int off, input int val);
        int info;
        int unsigned inf, newb;
        info = switch_info(mode, keyed_by_addr(mode) ? off : val);
        if (info < 0) return;
        inf  = info & 'hFFFF;
        newb = (pbank ^ ((pbank ^ inf) & (mode_mask(mode) | 'h4000))) & 'hFFFF;
        if (cls == CLS_SIC) begin
            // split enables only move for the low part of the control page
            if (off < 'h20) begin
                pbank = newb;
                split = (inf >> 13) & 3;
            end
        end else if (cls == CLS_OSS) begin
            small_sel = inf & 3;
        end else begin
            pbank = newb;
            pen   = (inf >> 14) & 1;
        end
    endfunction

    function automatic logic [7:0] ctl_read(input logic [7:0] o, input logic din);
        if (o inside {[OFF_PBANK_LO:OFF_LOCK]} && !locked) begin
            case (o)
                OFF_PBANK_LO: return pbank[7:0];
                OFF_PBANK_HI: return pbank[15:8];
                OFF_PEN:      return {7'd0, pen};
                OFF_SBANK_LO: return sbank[7:0];
                OFF_SBANK_HI: return {2'd0, sbank[13:8]};
                OFF_SEN:      return {7'd0, sen};
                OFF_MODE:     return {2'd0, mode};
                OFF_SRC:      return {4'd0, src};
                OFF_SPI:      return {din, 5'd0, spi[1:0]};
                default:      return 8'hFF;
            endcase
        end
        if (cls == CLS_SIC && o < 8'h20)
            return {1'b0, ~pen, sen, pbank[5:1]};
        if (keyed_by_addr(mode)) switch_banks(o, 0);
        return 8'hFF;
    endfunction

    function automatic void ctl_write(input logic [7:0] o, input logic [7:0] v);
        if (o inside {[OFF_PBANK_LO:OFF_LOCK]} && !locked) begin
            case (o)
                OFF_PBANK_LO: begin pen = 1; pbank[7:0] = v; end
                OFF_PBANK_HI: begin pen = 1; pbank[15:8] = {2'd0, v[5:0]}; end
                OFF_PEN:      pen = v[0];
                OFF_SBANK_LO: begin sen = 1; sbank[7:0] = v; end
                OFF_SBANK_HI: begin sen = 1; sbank[13:8] = v[5:0]; end
                OFF_SEN:      sen = v[0];
                OFF_MODE: begin
                    mode = v[5:0];
                    cls  = mode_class(mode, cls);
                end
                OFF_SRC:  src = v[3:0];
                OFF_SPI:  spi = v & 8'h83;
                OFF_LOCK: locked = 1;
                default: ;
            endcase
            return;
        end
        switch_banks(o, v);
    endfunction

    // applies one accepted item to the shadow state and returns its mapping
    function automatic map_result_t predict_mapping(input bus_item_t it);
        map_result_t r;
        int unsigned msk, pb, sb, ub, lb, b, a;
        logic uwe, lwe;
        r = '{default: '0};
        r.rd = 8'hFF;
        if (it.cmd == CMD_READ) r.rd = ctl_read(it.off, it.din);
        else if (it.cmd == CMD_WRITE) ctl_write(it.off, it.dat);
        msk = (32'd1 << ((size_log2 > 27) ? 27 : size_log2)) - 1;
        pb = pbank & 'h3FFF;
        sb = sbank;
        ub = 0;
        lb = 0;
        b  = pb & ~32'd1;
        case (cls)
            CLS_8K: if (pen) begin r.uon = 1; ub = pb; r.uram = src[1]; end
            CLS_16K: if (pen) begin
                r.uon = 1; r.lon = 1; ub = b + 1; lb = b;
                r.uram = src[1]; r.lram = src[1];
            end
            CLS_FLEXI: begin
                if (pen) begin r.uon = 1; ub = pb; r.uram = src[1]; end
                if (sen) begin r.lon = 1; lb = sb; r.lram = src[3]; end
            end
            CLS_FIXED: if (pen) begin
                r.uon = 1; r.lon = 1; ub = pb | mode_mask(mode); lb = pb;
                r.uram = src[1]; r.lram = src[1];
            end
            CLS_OSS: if (pen) begin
                r.uon = 1; r.lon = 1; r.u4k = 1; r.l4k = 1; ub = pb;
                r.uram = src[1]; r.lram = src[1];
            end
            CLS_SIC: if (pen) begin
                if (split[1]) begin r.uon = 1; ub = b + 1; r.uram = src[1]; end
                if (split[0]) begin r.lon = 1; lb = b; r.lram = src[1]; end
            end
            default: ;
        endcase
        if (r.uon) r.uoff = (ub << 13) & msk;
        if (r.lon) begin
            // oss lower half picks a 4k slice of the even bank
            if (cls == CLS_OSS) r.loff = ((b << 13) + small_sel * 'h1000) & msk;
            else r.loff = (lb << 13) & msk;
        end
        uwe = r.uon && src[0];
        if (cls inside {CLS_OFF, CLS_8K, CLS_FLEXI}) lwe = r.lon && src[2];
        else lwe = r.lon && src[0];
        a = it.addr;
        if (it.cmd == CMD_WINDOW && a < 'hC000) begin
            if (r.uon && r.u4k && a >= 'hB000) begin
                r.full = r.uoff + (a - 'hB000); r.wr = uwe;
            end else if (r.lon && r.l4k && a >= 'hA000 && a < 'hB000) begin
                r.full = r.loff + (a - 'hA000); r.wr = lwe;
            end else if (r.uon && !r.u4k && a >= 'hA000) begin
                r.full = r.uoff + (a - 'hA000); r.wr = uwe;
            end else if (r.lon && !r.l4k && a >= 'h8000 && a < 'hA000) begin
                r.full = r.loff + (a - 'h8000); r.wr = lwe;
            end
        end
        r.spi = {spi[7], ~spi[1], spi[0]};
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic bus_item_t row(input t_cmd c, input logic [7:0] o, input logic [7:0] d,
                                      input logic [15:0] a, input logic din,
                                      input bit has_rd = 0, input logic [7:0] rd = 8'hFF);
        bus_item_t it;
        it = '{c, o, d, a, din, has_rd, rd};
        return it;
    endfunction

    // mostly register and bank traffic, weighted towards modes that exist
    function automatic bus_item_t random_item(input bit lockable);
        logic [5:0] modes[24] = '{6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h08, 6'h09, 6'h0A,
                                  6'h0C, 6'h0D, 6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h28,
                                  6'h2B, 6'h2F, 6'h30, 6'h35, 6'h38, 6'h3D, 6'h3F, 6'h05};
        bus_item_t it;
        int sel;
        sel = $urandom_range(0, 19);
        it.cmd = (sel < 5) ? CMD_READ : (sel < 13) ? CMD_WRITE : (sel < 19) ? CMD_WINDOW : CMD_NONE;
        sel = $urandom_range(0, 9);
        if (sel < 5) it.off = OFF_PBANK_LO + $urandom_range(0, 8);
        else if (sel == 5) it.off = 8'hA9 + $urandom_range(0, 6);
        else if (sel < 8) it.off = $urandom_range(0, 8'h1F);
        else it.off = $urandom_range(0, 255);
        if (it.off == OFF_LOCK && !lockable) it.off = 8'hAE;
        it.dat = $urandom_range(0, 255);
        if (it.off == OFF_MODE && $urandom_range(0, 9) < 7) it.dat = modes[$urandom_range(0, 23)];
        it.addr = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 16'hFFFF)
                                               : $urandom_range(16'h8000, 16'hBFFF);
        it.din = $urandom_range(0, 1);
        it.has_rd = 0;
        it.rd = 8'hFF;
        return it;
    endfunction

    // offer one item from a falling edge until it is taken
    task automatic send_item(input bus_item_t it);
        map_result_t r;
        if (!no_idle && $urandom_range(0, 2) == 0) begin
            i_valid = 1'b0;
            repeat (gap_len()) @(negedge i_clk);
        end
        i_command = it.cmd;
        i_control_offset = it.off;
        i_write_data = it.dat;
        i_window_address = it.addr;
        i_spi_data_in = it.din;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = predict_mapping(it);
        // typed rows pin the read byte directly
        if (it.has_rd) r.rd = it.rd;
        mapping_q.push_back(r);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (mapping_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [4:0] v);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        size_log2 = v;
    endtask

    task automatic run_phase(input logic [4:0] cfg, input int n, input bit lockable);
        drain();
        write_size(cfg);
        repeat (n) send_item(random_item(lockable));
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_stall = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                i_stall = 1'b1;
                repeat (gap_len()) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        map_result_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (mapping_q.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                e = mapping_q.pop_front();
                check_field("read_data", e.rd, o_read_data);
                check_field("upper_window_on", e.uon, o_upper_window_on);
                check_field("upper_window_4k", e.u4k, o_upper_window_4k);
                check_field("upper_offset", e.uoff, o_upper_offset);
                check_field("upper_in_ram", e.uram, o_upper_in_ram);
                check_field("lower_window_on", e.lon, o_lower_window_on);
                check_field("lower_window_4k", e.l4k, o_lower_window_4k);
                check_field("lower_offset", e.loff, o_lower_offset);
                check_field("lower_in_ram", e.lram, o_lower_in_ram);
                check_field("full_address", e.full, o_full_address);
                check_field("access_writable", e.wr, o_access_writable);
                check_field("spi_pins", e.spi, o_spi_pins);
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    bus_item_t directed[$];

    initial begin
        // shadow state as after reset
        pbank = '0; pen = 1; sbank = '0; sen = 0; mode = 6'h01; src = '0;
        spi = 8'h82; locked = 0; cls = CLS_8K; split = 2'b10; small_sel = '0;
        size_log2 = 5'd24;

        // reset state, extremes and each mode family
        directed.push_back(row(CMD_READ, OFF_MODE, 8'h00, 16'h8000, 1'b0, 1, 8'h01));
        directed.push_back(row(CMD_READ, OFF_SPI, 8'h00, 16'h8000, 1'b1, 1, 8'h82));
        directed.push_back(row(CMD_READ, OFF_PEN, 8'h00, 16'h8000, 1'b0, 1, 8'h01));
        // unused control offset answers nothing
        directed.push_back(row(CMD_READ, 8'hAA, 8'h00, 16'h8000, 1'b0, 1, 8'hFF));
        directed.push_back(row(CMD_WINDOW, 8'h00, 8'h00, 16'hA000, 1'b0));
        // address outside every mapped window
        directed.push_back(row(CMD_WINDOW, 8'h00, 8'h00, 16'h8000, 1'b0));
        directed.push_back(row(CMD_WRITE, OFF_PBANK_LO, 8'hFF, 16'h8000, 1'b0));
        directed.push_back(row(CMD_WRITE, OFF_PBANK_HI, 8'hFF, 16'h8000, 1'b0));
        directed.push_back(row(CMD_READ, OFF_PBANK_HI, 8'h00, 16'h8000, 1'b0, 1, 8'h3F));
        directed.push_back(row(CMD_WRITE, OFF_SRC, 8'hFF, 16'h8000, 1'b0));
        directed.push_back(row(CMD_WINDOW, 8'h00, 8'h00, 16'hBFFF, 1'b0));
        directed.push_back(row(CMD_WRITE, OFF_MODE, 8'h04, 16'h8000, 1'b0));
        directed.push_back(row(CMD_READ, 8'hD9, 8'h00, 16'h8000, 1'b0, 1, 8'hFF));
        directed.push_back(row(CMD_WINDOW, 8'h00, 8'h00, 16'hA7FF, 1'b0));
        directed.push_back(row(CMD_WRITE, OFF_MODE, 8'h24, 16'h8000, 1'b0));
        directed.push_back(row(CMD_WRITE, 8'h10, 8'h7F, 16'h8000, 1'b0));
        directed.push_back(row(CMD_READ, 8'h05, 8'h00, 16'h8000, 1'b0));
        directed.push_back(row(CMD_WRITE, OFF_MODE, 8'h20, 16'h8000, 1'b0));
        directed.push_back(row(CMD_WRITE, OFF_SBANK_HI, 8'hFF, 16'h8000, 1'b0));
        directed.push_back(row(CMD_WINDOW, 8'h00, 8'h00, 16'h9FFF, 1'b0));
        // meaningless mode code keeps the window class
        directed.push_back(row(CMD_WRITE, OFF_MODE, 8'h3F, 16'h8000, 1'b0));
        directed.push_back(row(CMD_WRITE, OFF_MODE, 8'h00, 16'h8000, 1'b0));
        directed.push_back(row(CMD_WRITE, OFF_SPI, 8'h01, 16'h8000, 1'b0));
        directed.push_back(row(CMD_NONE, 8'hFF, 8'hFF, 16'hFFFF, 1'b1));
        directed.push_back(row(CMD_WINDOW, 8'h00, 8'h00, 16'h0000, 1'b0));

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_size(5'd24);
        foreach (directed[i]) send_item(directed[i]);

        // long receiver hold-off while items keep coming
        drain();
        hold_req = 1;
        run_phase(5'd13, 150, 0);
        no_idle = 1;
        run_phase(5'd27, 150, 0);
        no_idle = 0;
        run_phase(5'd31, 150, 0);
        run_phase(5'd18, 150, 0);
        run_phase(5'($urandom_range(13, 27)), 150, 0);
        // lock the register page, after which it only switches banks
        drain();
        write_size(5'd20);
        send_item(row(CMD_WRITE, OFF_LOCK, 8'h00, 16'h8000, 1'b0));
        repeat (150) send_item(random_item(1));

        drain();
        repeat (6) @(posedge i_clk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
rtl/cbsc_pkg.sv
rtl/cbsc_map.sv
rtl/cartridge_bank_switch_controller_top.sv
test/tb_top.sv
